@@ sv/bqef_pkg.sv @@
// bqef_pkg: shared types, constants and helpers for the billboard quad expander
// used by every module of the block but bqef_checker; depends on nothing
package bqef_pkg;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned FadeQW  = 16;  // quotient bits of both fade dividers
  localparam int unsigned LifeW   = 24;
  localparam int unsigned SumW    = 56;  // squared eye distance
  localparam int unsigned DistW   = SumW / 2;
  localparam int unsigned NfW     = 32;  // near-fade divider width

  typedef enum logic [CfgIdxW-1:0] {
    CFG_EYE_X, CFG_EYE_Y, CFG_EYE_Z, CFG_TGT_X, CFG_TGT_Y, CFG_TGT_Z, CFG_RADIUS
  } cfg_idx_e;

  localparam logic [31:0] TargetZReset = 32'h0001_0000;
  localparam logic [30:0] RadiusReset  = 31'd6553600;
  localparam logic [1:0]  KindEffect   = 2'd2;
  localparam logic [LifeW-1:0] LifeTiny = 24'd65;
  localparam logic [LifeW-1:0] LifeOne  = 24'd65536;
  localparam logic [16:0] FadeOne = 17'h1_0000;

  // per-corner tables, bit k for vertex k
  localparam logic [5:0] CornerRNeg = 6'b001011;
  localparam logic [5:0] CornerUNeg = 6'b101001;
  localparam logic [5:0] CornerTexU = 6'b110100;
  localparam logic [5:0] CornerTexV = 6'b101001;
  localparam logic [2:0] LastVertex = 3'd5;

  typedef struct packed {
    logic [2:0][31:0] r;
    logic [2:0][31:0] u;
  } basis_t;

  typedef struct packed {
    logic [2:0][31:0] pos;
    logic [31:0]      color;
    logic [2:0][32:0] rs;
    logic [2:0][32:0] us;
  } geo_t;

  typedef struct packed {
    geo_t            geo;
    logic            near_en;
    logic            full;
    logic [SumW-1:0] sum;
  } lp_t;

  typedef struct packed {
    geo_t        geo;
    logic        near_en;
    logic [16:0] fade_l;
  } sp_t;

  typedef struct packed {
    geo_t        geo;
    logic        in_band;
    logic [16:0] fade_l;
  } np_t;

  function automatic logic [31:0] sat32(logic signed [34:0] s);
    logic [31:0] res;
    if (s[34:31] == 4'b0000 || s[34:31] == 4'b1111) res = s[31:0];
    else if (s[34]) res = 32'h8000_0000;
    else res = 32'h7FFF_FFFF;
    return res;
  endfunction

endpackage

@@ sv/bqef_basis.sv @@
// bqef_basis: iterative camera basis unit, right and up unit vectors in Q2.30
// recomputed after reset and after every register write; uses bqef_pkg
module bqef_basis import bqef_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             restart_i,
  input  logic [2:0][31:0] eye_i,
  input  logic [2:0][31:0] target_i,
  output basis_t           basis_o,
  output logic             busy_o
);

  typedef enum logic [2:0] {
    B_IDLE, B_LOAD, B_NORM, B_SQ, B_SQRT, B_DIV, B_DONE, B_CROSS
  } bstate_e;

  bstate_e state_q;
  logic    phase_q;
  logic signed [33:0] v_q [3];
  logic signed [31:0] w_q [3];
  logic signed [31:0] f_q [3];
  logic signed [31:0] r_q [3];
  logic signed [31:0] u_q [3];
  logic [1:0]  idx_q;
  logic [4:0]  cnt_q;
  logic [63:0] acc_q, root_q, bit_q;
  logic [31:0] rem_q;
  logic [29:0] quo_q;

  logic [33:0] mag [3];
  logic [33:0] m;
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] prod;
  logic [64:0] trial_s;
  logic        sge;
  logic [31:0] a_mag;
  logic [32:0] trial_d;
  logic        dge;
  logic [30:0] qfull;
  logic [31:0] res;
  logic signed [31:0] cur;

  always_comb begin
    for (int i = 0; i < 3; i++) mag[i] = v_q[i][33] ? 34'(-v_q[i]) : 34'(v_q[i]);
    m = mag[0];
    if (mag[1] > m) m = mag[1];
    if (mag[2] > m) m = mag[2];
    cur = v_q[idx_q][31:0];
    mul_a = cur;
    mul_b = cur;
    if (state_q == B_CROSS) begin
      case (cnt_q[1:0])
        2'd0:    begin mul_a = f_q[1]; mul_b = r_q[2]; end
        2'd1:    begin mul_a = f_q[2]; mul_b = r_q[0]; end
        2'd2:    begin mul_a = f_q[0]; mul_b = r_q[2]; end
        default: begin mul_a = f_q[1]; mul_b = r_q[0]; end
      endcase
    end
    prod    = mul_a * mul_b;
    trial_s = {1'b0, root_q} + {1'b0, bit_q};
    sge     = {1'b0, acc_q} >= trial_s;
    a_mag   = cur[31] ? 32'(-cur) : 32'(cur);
    trial_d = (cnt_q == 5'd0) ? {1'b0, a_mag} : {rem_q, 1'b0};
    dge     = trial_d >= {1'b0, root_q[31:0]};
    qfull   = {quo_q, dge};
    res     = cur[31] ? 32'(-{1'b0, qfull}) : {1'b0, qfull};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_LOAD;
      phase_q <= 1'b0;
      idx_q   <= '0;
      cnt_q   <= '0;
    end else if (restart_i) begin
      state_q <= B_LOAD;
      phase_q <= 1'b0;
    end else begin
      case (state_q)
        B_LOAD: begin
          for (int i = 0; i < 3; i++)
            v_q[i] <= 34'($signed(target_i[i])) - 34'($signed(eye_i[i]));
          state_q <= B_NORM;
        end
        B_NORM: begin
          if (m == '0) begin
            for (int i = 0; i < 3; i++) w_q[i] <= '0;
            state_q <= B_DONE;
          end else if (m[33:31] != 3'b000) begin
            for (int i = 0; i < 3; i++) v_q[i] <= v_q[i] >>> 1;
          end else if (!m[30]) begin
            for (int i = 0; i < 3; i++) v_q[i] <= v_q[i] <<< 1;
          end else begin
            idx_q   <= '0;
            acc_q   <= '0;
            state_q <= B_SQ;
          end
        end
        B_SQ: begin
          acc_q <= acc_q + 64'(prod);
          if (idx_q == 2'd2) begin
            root_q  <= '0;
            bit_q   <= 64'd1 << 62;
            cnt_q   <= '0;
            state_q <= B_SQRT;
          end else begin
            idx_q <= idx_q + 2'd1;
          end
        end
        B_SQRT: begin
          if (sge) begin
            acc_q  <= acc_q - trial_s[63:0];
            root_q <= (root_q >> 1) + bit_q;
          end else begin
            root_q <= root_q >> 1;
          end
          bit_q <= bit_q >> 2;
          cnt_q <= cnt_q + 5'd1;
          if (cnt_q == 5'd31) begin
            idx_q   <= '0;
            cnt_q   <= '0;
            state_q <= B_DIV;
          end
        end
        B_DIV: begin
          // restoring divide |c| * 2^30 / len, one quotient bit a cycle
          rem_q <= dge ? 32'(trial_d - {1'b0, root_q[31:0]}) : trial_d[31:0];
          quo_q <= qfull[29:0];
          if (cnt_q == 5'd30) begin
            w_q[idx_q] <= res;
            cnt_q      <= '0;
            if (idx_q == 2'd2) state_q <= B_DONE;
            else idx_q <= idx_q + 2'd1;
          end else begin
            cnt_q <= cnt_q + 5'd1;
          end
        end
        B_DONE: begin
          if (!phase_q) begin
            for (int i = 0; i < 3; i++) f_q[i] <= w_q[i];
            // right = world up x forward, before normalising
            v_q[0]  <= 34'(w_q[2]);
            v_q[1]  <= '0;
            v_q[2]  <= -34'(w_q[0]);
            phase_q <= 1'b1;
            state_q <= B_NORM;
          end else begin
            for (int i = 0; i < 3; i++) r_q[i] <= w_q[i];
            cnt_q   <= '0;
            state_q <= B_CROSS;
          end
        end
        B_CROSS: begin
          cnt_q <= cnt_q + 5'd1;
          case (cnt_q[1:0])
            2'd0:    u_q[0] <= 32'(prod >>> 30);
            2'd1:    acc_q  <= 64'(prod);
            2'd2:    u_q[1] <= 32'(($signed(acc_q) - prod) >>> 30);
            default: begin
              u_q[2]  <= 32'((-prod) >>> 30);
              state_q <= B_IDLE;
            end
          endcase
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      basis_o.r[i] = r_q[i];
      basis_o.u[i] = u_q[i];
    end
  end

  assign busy_o = (state_q != B_IDLE);

endmodule

@@ sv/bqef_div_pipe.sv @@
// bqef_div_pipe: pipelined restoring divider, one quotient bit per stage
// carries a payload beside the quotient; uses bqef_pkg
module bqef_div_pipe import bqef_pkg::*; #(
  parameter int unsigned NW = 24,
  parameter int unsigned QW = FadeQW,
  parameter int unsigned PW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          adv_i,
  input  logic          valid_i,
  input  logic [NW-1:0] rem_i,   // must be below den_i
  input  logic [NW-1:0] den_i,
  input  logic [PW-1:0] pay_i,
  output logic          valid_o,
  output logic [QW-1:0] quo_o,
  output logic [PW-1:0] pay_o
);

  logic          vld_q [QW];
  logic [NW-1:0] rem_q [QW];
  logic [NW-1:0] den_q [QW];
  logic [QW-1:0] quo_q [QW];
  logic [PW-1:0] pay_q [QW];

  for (genvar i = 0; i < QW; i++) begin : g_st
    logic          v_in;
    logic [NW-1:0] rem_in, den_in;
    logic [QW-1:0] quo_in;
    logic [PW-1:0] pay_in;
    logic [NW:0]   trial;
    logic          ge;

    if (i == 0) begin : g_first
      assign v_in   = valid_i;
      assign rem_in = rem_i;
      assign den_in = den_i;
      assign quo_in = '0;
      assign pay_in = pay_i;
    end else begin : g_next
      assign v_in   = vld_q[i-1];
      assign rem_in = rem_q[i-1];
      assign den_in = den_q[i-1];
      assign quo_in = quo_q[i-1];
      assign pay_in = pay_q[i-1];
    end

    assign trial = {rem_in, 1'b0};
    assign ge    = trial >= {1'b0, den_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) vld_q[i] <= 1'b0;
      else if (adv_i) vld_q[i] <= v_in;
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        rem_q[i] <= ge ? NW'(trial - {1'b0, den_in}) : trial[NW-1:0];
        den_q[i] <= den_in;
        quo_q[i] <= {quo_in[QW-2:0], ge};
        pay_q[i] <= pay_in;
      end
    end
  end

  assign valid_o = vld_q[QW-1];
  assign quo_o   = quo_q[QW-1];
  assign pay_o   = pay_q[QW-1];

endmodule

@@ sv/bqef_sqrt_pipe.sv @@
// bqef_sqrt_pipe: pipelined floor integer square root, one result bit per stage
// carries a payload beside the root; uses bqef_pkg
module bqef_sqrt_pipe import bqef_pkg::*; #(
  parameter int unsigned XW = SumW,
  parameter int unsigned PW = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             adv_i,
  input  logic             valid_i,
  input  logic [XW-1:0]    x_i,
  input  logic [PW-1:0]    pay_i,
  output logic             valid_o,
  output logic [XW/2-1:0]  root_o,
  output logic [PW-1:0]    pay_o
);

  localparam int unsigned NS = XW / 2;

  logic          vld_q [NS];
  logic [XW-1:0] x_q   [NS];
  logic [XW:0]   r_q   [NS];
  logic [PW-1:0] pay_q [NS];

  for (genvar i = 0; i < NS; i++) begin : g_st
    localparam logic [XW:0] Bit = (XW+1)'(1) << (XW - 2 - 2*i);
    logic          v_in;
    logic [XW-1:0] x_in;
    logic [XW:0]   r_in, trial;
    logic [PW-1:0] pay_in;
    logic          ge;

    if (i == 0) begin : g_first
      assign v_in   = valid_i;
      assign x_in   = x_i;
      assign r_in   = '0;
      assign pay_in = pay_i;
    end else begin : g_next
      assign v_in   = vld_q[i-1];
      assign x_in   = x_q[i-1];
      assign r_in   = r_q[i-1];
      assign pay_in = pay_q[i-1];
    end

    assign trial = r_in + Bit;
    assign ge    = {1'b0, x_in} >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) vld_q[i] <= 1'b0;
      else if (adv_i) vld_q[i] <= v_in;
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        x_q[i]   <= ge ? XW'({1'b0, x_in} - trial) : x_in;
        r_q[i]   <= ge ? (r_in >> 1) + Bit : r_in >> 1;
        pay_q[i] <= pay_in;
      end
    end
  end

  assign valid_o = vld_q[NS-1];
  assign root_o  = r_q[NS-1][NS-1:0];
  assign pay_o   = pay_q[NS-1];

endmodule

@@ sv/billboard_quad_expand_fade.sv @@
// channel   | handshake                   | beat
// ----------+-----------------------------+-----------------------------------------
// particle  | start_i & !busy_o           | position, half size, life, kind, colour
// vertex    | valid_o, one cycle, no hold | coordinates, colour, u, v, last flag
// register  | cfg_valid_i & cfg_ready_o   | cfg_index_i, cfg_data_i
//
// a live particle gives six vertices on consecutive cycles; the vertex emitter takes a
// new live particle only when idle or on its last vertex, dead particles can enter
// every cycle while busy_o is low
// after reset and after each register write the iterative basis unit holds busy_o
// until the new basis is ready; when the emitter is full the whole pipeline holds
// top level of the billboard quad expander; uses bqef_pkg, bqef_basis,
// bqef_div_pipe and bqef_sqrt_pipe
module billboard_quad_expand_fade import bqef_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] pos_z_i,
  input  logic [30:0]        half_size_i,
  input  logic signed [23:0] life_left_i,
  input  logic [23:0]        life_total_i,
  input  logic [1:0]         particle_kind_i,
  input  logic [31:0]        base_color_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  output logic               valid_o,
  output logic signed [31:0] vert_x_o,
  output logic signed [31:0] vert_y_o,
  output logic signed [31:0] vert_z_o,
  output logic [31:0]        vert_color_o,
  output logic               tex_u_o,
  output logic               tex_v_o,
  output logic               last_vertex_o
);

  // registers
  logic [2:0][31:0] eye_q, tgt_q;
  logic [30:0]      radius_q;
  basis_t           basis;
  logic             basis_busy;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eye_q    <= '0;
      tgt_q    <= {TargetZReset, 32'd0, 32'd0};
      radius_q <= RadiusReset;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_EYE_X:  eye_q[0] <= cfg_data_i;
        CFG_EYE_Y:  eye_q[1] <= cfg_data_i;
        CFG_EYE_Z:  eye_q[2] <= cfg_data_i;
        CFG_TGT_X:  tgt_q[0] <= cfg_data_i;
        CFG_TGT_Y:  tgt_q[1] <= cfg_data_i;
        CFG_TGT_Z:  tgt_q[2] <= cfg_data_i;
        CFG_RADIUS: radius_q <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  bqef_basis u_basis (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .restart_i (cfg_valid_i),
    .eye_i     (eye_q),
    .target_i  (tgt_q),
    .basis_o   (basis),
    .busy_o    (basis_busy)
  );

  logic adv, take;
  logic accept;
  assign accept = start_i & ~busy_o;

  // stage 0: input beat
  logic             v0_q;
  logic [2:0][31:0] pos0_q;
  logic [30:0]      hs0_q;
  logic [23:0]      life0_q, tot0_q;
  logic [1:0]       kind0_q;
  logic [31:0]      col0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v0_q <= 1'b0;
    else if (adv) v0_q <= accept;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pos0_q  <= {pos_z_i, pos_y_i, pos_x_i};
      hs0_q   <= half_size_i;
      life0_q <= life_left_i;
      tot0_q  <= life_total_i;
      kind0_q <= particle_kind_i;
      col0_q  <= base_color_i;
    end
  end

  // stage 1: eye offset, band check, life fade operands
  logic signed [32:0] d0 [3];
  logic [32:0]        dmag [3];
  logic               far0, live0, near0, full0;
  logic [24:0]        l4;
  logic [23:0]        den0;

  always_comb begin
    far0 = 1'b0;
    for (int i = 0; i < 3; i++) begin
      d0[i]   = 33'($signed(pos0_q[i])) - 33'($signed(eye_q[i]));
      dmag[i] = d0[i][32] ? 33'(-d0[i]) : 33'(d0[i]);
      if (dmag[i][32:27] != 6'd0) far0 = 1'b1;
    end
    live0 = ($signed(life0_q) > 24'sd0);
    near0 = (kind0_q != KindEffect) && (radius_q != '0) && !far0;
    l4    = {life0_q[22:0], 2'b00};
    den0  = (tot0_q > LifeTiny) ? tot0_q : LifeOne;
    full0 = l4 >= {1'b0, den0};
  end

  logic             v1_q, near1_q, full1_q;
  logic [2:0][31:0] pos1_q;
  logic [31:0]      col1_q;
  logic [30:0]      hs1_q;
  logic [2:0][27:0] d1_q;
  logic [23:0]      den1_q, rem1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else if (adv) v1_q <= v0_q & live0;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pos1_q  <= pos0_q;
      col1_q  <= col0_q;
      hs1_q   <= hs0_q;
      for (int i = 0; i < 3; i++) d1_q[i] <= d0[i][27:0];
      near1_q <= near0;
      full1_q <= full0;
      den1_q  <= den0;
      rem1_q  <= full0 ? '0 : l4[23:0];
    end
  end

  // stage 2: squares and right offsets
  logic signed [55:0] sq_c [3];
  logic signed [63:0] rp_c [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sq_c[i] = $signed(d1_q[i]) * $signed(d1_q[i]);
      rp_c[i] = $signed(basis.r[i]) * $signed({1'b0, hs1_q});
    end
  end

  logic             v2_q, near2_q, full2_q;
  logic [2:0][31:0] pos2_q;
  logic [31:0]      col2_q;
  logic [30:0]      hs2_q;
  logic [2:0][55:0] sq2_q;
  logic [2:0][32:0] rs2_q;
  logic [23:0]      den2_q, rem2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else if (adv) v2_q <= v1_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pos2_q  <= pos1_q;
      col2_q  <= col1_q;
      hs2_q   <= hs1_q;
      for (int i = 0; i < 3; i++) begin
        sq2_q[i] <= sq_c[i];
        rs2_q[i] <= 33'(rp_c[i] >>> 30);
      end
      near2_q <= near1_q;
      full2_q <= full1_q;
      den2_q  <= den1_q;
      rem2_q  <= rem1_q;
    end
  end

  // stage 3: distance sum and up offsets
  logic signed [63:0] up_c [3];
  lp_t                lp_d;

  always_comb begin
    for (int i = 0; i < 3; i++) up_c[i] = $signed(basis.u[i]) * $signed({1'b0, hs2_q});
    lp_d.geo.pos   = pos2_q;
    lp_d.geo.color = col2_q;
    lp_d.geo.rs    = rs2_q;
    for (int i = 0; i < 3; i++) lp_d.geo.us[i] = 33'(up_c[i] >>> 30);
    lp_d.near_en = near2_q;
    lp_d.full    = full2_q;
    lp_d.sum     = sq2_q[0] + sq2_q[1] + sq2_q[2];
  end

  logic        v3_q;
  lp_t         lp3_q;
  logic [23:0] den3_q, rem3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else if (adv) v3_q <= v2_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      lp3_q  <= lp_d;
      den3_q <= den2_q;
      rem3_q <= rem2_q;
    end
  end

  // life fade divider
  logic                      vl;
  logic [FadeQW-1:0]         ql;
  logic [$bits(lp_t)-1:0]    lvec;
  lp_t                       lo;

  bqef_div_pipe #(.NW(LifeW), .QW(FadeQW), .PW($bits(lp_t))) u_life_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (v3_q),
    .rem_i   (rem3_q),
    .den_i   (den3_q),
    .pay_i   (lp3_q),
    .valid_o (vl),
    .quo_o   (ql),
    .pay_o   (lvec)
  );

  assign lo = lvec;

  sp_t sp_in;
  always_comb begin
    sp_in.geo     = lo.geo;
    sp_in.near_en = lo.near_en;
    sp_in.fade_l  = lo.full ? FadeOne : {1'b0, ql};
  end

  // eye distance
  logic                   vs;
  logic [DistW-1:0]       eye_dist;
  logic [$bits(sp_t)-1:0] svec;
  sp_t                    so;

  bqef_sqrt_pipe #(.XW(SumW), .PW($bits(sp_t))) u_dist_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (vl),
    .x_i     (lo.sum),
    .pay_i   (sp_in),
    .valid_o (vs),
    .root_o  (eye_dist),
    .pay_o   (svec)
  );

  assign so = svec;

  // stage 4: near-fade band and divider operands
  logic [34:0]        c100;
  logic [32:0]        r3;
  logic signed [35:0] num;
  logic               band;

  always_comb begin
    c100 = 35'(eye_dist) * 35'd100;
    r3   = 33'({radius_q, 1'b0}) + 33'(radius_q);
    num  = $signed({1'b0, c100}) - $signed(36'(radius_q));
    band = so.near_en && (c100 < 35'(r3));
  end

  logic            v4_q;
  np_t             np4_q;
  logic [NfW-1:0]  nrem4_q, nden4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v4_q <= 1'b0;
    else if (adv) v4_q <= vs;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      np4_q <= '{geo: so.geo, in_band: band, fade_l: so.fade_l};
      // a zero numerator yields a zero quotient, so clipping at zero comes free
      nrem4_q <= (band && num > 36'sd0) ? num[NfW-1:0] : '0;
      nden4_q <= {radius_q, 1'b0};
    end
  end

  logic                   vn;
  logic [FadeQW-1:0]      qn;
  logic [$bits(np_t)-1:0] nvec;
  np_t                    no;

  bqef_div_pipe #(.NW(NfW), .QW(FadeQW), .PW($bits(np_t))) u_near_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (v4_q),
    .rem_i   (nrem4_q),
    .den_i   (nden4_q),
    .pay_i   (np4_q),
    .valid_o (vn),
    .quo_o   (qn),
    .pay_o   (nvec)
  );

  assign no = nvec;

  // stage 5: combined fade
  logic [32:0] fprod;
  assign fprod = 33'(no.fade_l) * 33'(qn);

  logic        v5_q;
  geo_t        geo5_q;
  logic [16:0] fade5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v5_q <= 1'b0;
    else if (adv) v5_q <= vn;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      geo5_q  <= no.geo;
      fade5_q <= no.in_band ? fprod[32:16] : no.fade_l;
    end
  end

  // stage 6: faded alpha
  logic [24:0] aprod;
  assign aprod = 25'(geo5_q.color[31:24]) * 25'(fade5_q);

  logic v6_q;
  geo_t geo6_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v6_q <= 1'b0;
    else if (adv) v6_q <= v5_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      geo6_q <= '{pos: geo5_q.pos, color: {aprod[23:16], geo5_q.color[23:0]},
                  rs: geo5_q.rs, us: geo5_q.us};
    end
  end

  // vertex emitter
  logic       em_active_q;
  logic [2:0] em_k_q;
  geo_t       em_geo_q;

  assign take   = v6_q & (~em_active_q | (em_k_q == LastVertex));
  assign adv    = ~v6_q | take;
  assign busy_o = basis_busy | ~adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      em_active_q <= 1'b0;
      em_k_q      <= '0;
    end else if (take) begin
      em_active_q <= 1'b1;
      em_k_q      <= '0;
    end else if (em_active_q) begin
      if (em_k_q == LastVertex) em_active_q <= 1'b0;
      else em_k_q <= em_k_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) em_geo_q <= geo6_q;
  end

  function automatic logic [31:0] vcoord(logic [31:0] p, logic [32:0] rs, logic [32:0] us,
                                         logic rn, logic un);
    logic signed [34:0] a, b, c;
    a = 35'($signed(p));
    b = 35'($signed(rs));
    c = 35'($signed(us));
    return sat32(a + (rn ? -b : b) + (un ? -c : c));
  endfunction

  logic rneg, uneg;
  assign rneg = CornerRNeg[em_k_q];
  assign uneg = CornerUNeg[em_k_q];

  assign valid_o       = em_active_q;
  assign vert_x_o      = vcoord(em_geo_q.pos[0], em_geo_q.rs[0], em_geo_q.us[0], rneg, uneg);
  assign vert_y_o      = vcoord(em_geo_q.pos[1], em_geo_q.rs[1], em_geo_q.us[1], rneg, uneg);
  assign vert_z_o      = vcoord(em_geo_q.pos[2], em_geo_q.rs[2], em_geo_q.us[2], rneg, uneg);
  assign vert_color_o  = em_geo_q.color;
  assign tex_u_o       = CornerTexU[em_k_q];
  assign tex_v_o       = CornerTexV[em_k_q];
  assign last_vertex_o = em_active_q & (em_k_q == LastVertex);

endmodule

@@ sv/bqef_checker.sv @@
// bqef_checker: port-level checks on the billboard quad expander
// bound to billboard_quad_expand_fade; depends on nothing else
module bqef_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        busy_o,
  input logic        cfg_valid_i,
  input logic        cfg_ready_o,
  input logic        valid_o,
  input logic [31:0] vert_color_o,
  input logic        tex_u_o,
  input logic        tex_v_o,
  input logic        last_vertex_o
);

  // a quad's six vertices come back to back
  a_quad_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !last_vertex_o |=> valid_o)
    else $error("vertex run broken before last vertex");

  // one colour for the whole quad
  a_quad_color: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !last_vertex_o |=> $stable(vert_color_o))
    else $error("colour changed inside a quad");

  a_last_corner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_vertex_o |-> valid_o && tex_u_o && tex_v_o)
    else $error("last vertex flag on wrong corner");

  // basis recompute blocks new particles
  a_cfg_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && cfg_ready_o |=> busy_o)
    else $error("not busy after register write");

endmodule

bind billboard_quad_expand_fade bqef_checker u_bqef_checker (.*);
